>>> rtl/rgb_pixel_blend_unit_assert.svh
// Assertion macros for the pixel blend unit.
// Needs clk and rst_n in the including scope; empty when SYNTHESIS is defined.
`ifndef RGB_PIXEL_BLEND_UNIT_ASSERT_SVH
`define RGB_PIXEL_BLEND_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RPB_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rpb: implication check failed");
`define RPB_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rpb: next-cycle check failed");
`else
`define RPB_ASSERT_IMP(label, pre, post)
`define RPB_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> rtl/rpb_pkg.sv
// Package for the pixel blend unit: payload structs, blend codes, register indexes.
// No dependencies.
package rpb_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned NUM_CH = 3;

    typedef enum logic [2:0] {
        FUNC_MULTIPLY = 3'd0,
        FUNC_SUBTRACT = 3'd1,
        FUNC_SCREEN   = 3'd2,
        FUNC_OVERLAY  = 3'd3,
        FUNC_ADD      = 3'd4,
        FUNC_SCALE    = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        CFG_ADD_CHANNEL = 2'd0,
        CFG_ADD_AMOUNT  = 2'd1,
        CFG_RED_GAIN    = 2'd2,
        CFG_BLUE_GAIN   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_DIV    = 2'd0,  // rounded product / 255
        KIND_SAT    = 2'd1,  // product clamped to 255
        KIND_DIRECT = 2'd2   // value already final
    } kind_t;

    typedef struct packed {
        logic [2:0]        func;
        logic [CHAN_W-1:0] top_red;
        logic [CHAN_W-1:0] top_green;
        logic [CHAN_W-1:0] top_blue;
        logic [CHAN_W-1:0] bottom_red;
        logic [CHAN_W-1:0] bottom_green;
        logic [CHAN_W-1:0] bottom_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } pixel_out_t;

    // Operand select stage, one per channel
    typedef struct packed {
        kind_t             kind;
        logic              inv;
        logic              dbl;
        logic [CHAN_W-1:0] op_a;
        logic [CHAN_W-1:0] op_b;
        logic [CHAN_W-1:0] direct;
    } ch_sel_t;

    // Product stage
    typedef struct packed {
        kind_t             kind;
        logic              inv;
        logic [16:0]       prod;
        logic [CHAN_W-1:0] direct;
    } ch_mul_t;

    // Quotient estimate stage
    typedef struct packed {
        logic              is_div;
        logic              inv;
        logic [16:0]       num;
        logic [8:0]        quot;
        logic [CHAN_W-1:0] direct;
    } ch_quot_t;

endpackage

>>> rtl/rgb_pixel_blend_unit.sv
// Top level of the pixel blend unit: four-stage pipeline plus config registers.
// Depends on rpb_pkg and rgb_pixel_blend_unit_assert.svh.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    in_data   (rpb_pkg::pixel_in_t)
//   out       output     out_valid / out_ready  out_data  (rpb_pkg::pixel_out_t)
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel per clock while the output is not stalled; an accepted pixel passes the
// s1, s2, s3 and s4 registers in turn, and s4 drives out_valid.
// Stages: operand select, 8x8 multiply, divide-by-255 estimate, correct and finish.
// The last stage is the output register. Each stage fills when it is empty or its
// successor moves, so bubbles collapse and a stall holds a stage only when all after it are full.
// Reset clears the valid bits and loads the register defaults; cfg_ready stays high.
`include "rgb_pixel_blend_unit_assert.svh"

module rgb_pixel_blend_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpb_pkg::pixel_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rpb_pkg::pixel_out_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);

    localparam int unsigned NCH = rpb_pkg::NUM_CH;
    localparam int unsigned CW  = rpb_pkg::CHAN_W;

    // configuration registers
    logic [1:0]        add_channel_reg;
    logic signed [8:0] add_amount_reg;
    logic [CW-1:0]     red_gain_reg;
    logic [CW-1:0]     blue_gain_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    rpb_pkg::ch_sel_t  s1_next [NCH];
    rpb_pkg::ch_sel_t  s1_reg  [NCH];
    rpb_pkg::ch_mul_t  s2_next [NCH];
    rpb_pkg::ch_mul_t  s2_reg  [NCH];
    rpb_pkg::ch_quot_t s3_next [NCH];
    rpb_pkg::ch_quot_t s3_reg  [NCH];
    logic [CW-1:0]     s4_next [NCH];
    logic [CW-1:0]     s4_reg  [NCH];

    logic [CW-1:0] top_ch [NCH];
    logic [CW-1:0] bot_ch [NCH];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_channel_reg <= 2'd0;
            add_amount_reg  <= 9'sd0;
            red_gain_reg    <= 8'd1;
            blue_gain_reg   <= 8'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rpb_pkg::CFG_ADD_CHANNEL: add_channel_reg <= cfg_data[1:0];
                rpb_pkg::CFG_ADD_AMOUNT:  add_amount_reg  <= $signed(cfg_data);
                rpb_pkg::CFG_RED_GAIN:    red_gain_reg    <= cfg_data[CW-1:0];
                rpb_pkg::CFG_BLUE_GAIN:   blue_gain_reg   <= cfg_data[CW-1:0];
                default:                  ;
            endcase
        end
    end

    // a stage moves when it is empty or the next one moves
    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    assign top_ch[0] = in_data.top_red;
    assign top_ch[1] = in_data.top_green;
    assign top_ch[2] = in_data.top_blue;
    assign bot_ch[0] = in_data.bottom_red;
    assign bot_ch[1] = in_data.bottom_green;
    assign bot_ch[2] = in_data.bottom_blue;

    // stage 1: pick multiplier operands, or finish subtract/add/pass directly
    always_comb
    begin
        logic signed [9:0] sum;
        sum = $signed({2'b00, top_ch[0]});
        for (int k = 0; k < NCH; k++)
        begin
            s1_next[k].kind   = rpb_pkg::KIND_DIRECT;
            s1_next[k].inv    = 1'b0;
            s1_next[k].dbl    = 1'b0;
            s1_next[k].op_a   = top_ch[k];
            s1_next[k].op_b   = bot_ch[k];
            s1_next[k].direct = top_ch[k];
            case (in_data.func)
                rpb_pkg::FUNC_MULTIPLY:
                begin
                    s1_next[k].kind = rpb_pkg::KIND_DIV;
                end
                rpb_pkg::FUNC_SUBTRACT:
                begin
                    s1_next[k].direct = (bot_ch[k] > top_ch[k]) ?
                                        bot_ch[k] - top_ch[k] : '0;
                end
                rpb_pkg::FUNC_SCREEN:
                begin
                    s1_next[k].kind = rpb_pkg::KIND_DIV;
                    s1_next[k].inv  = 1'b1;
                    s1_next[k].op_a = ~top_ch[k];
                    s1_next[k].op_b = ~bot_ch[k];
                end
                rpb_pkg::FUNC_OVERLAY:
                begin
                    s1_next[k].kind = rpb_pkg::KIND_DIV;
                    s1_next[k].dbl  = 1'b1;
                    // bright bottom: doubled screen form
                    if (bot_ch[k][CW-1])
                    begin
                        s1_next[k].inv  = 1'b1;
                        s1_next[k].op_a = ~top_ch[k];
                        s1_next[k].op_b = ~bot_ch[k];
                    end
                end
                rpb_pkg::FUNC_ADD:
                begin
                    if (add_channel_reg == 2'(k))
                    begin
                        sum = $signed({2'b00, top_ch[k]})
                            + $signed({add_amount_reg[8], add_amount_reg});
                        if (sum < 0)
                            s1_next[k].direct = '0;
                        else if (sum > 10'sd255)
                            s1_next[k].direct = '1;
                        else
                            s1_next[k].direct = sum[CW-1:0];
                    end
                end
                rpb_pkg::FUNC_SCALE:
                begin
                    if (k == 0)
                    begin
                        s1_next[k].kind = rpb_pkg::KIND_SAT;
                        s1_next[k].op_b = red_gain_reg;
                    end
                    else if (k == NCH - 1)
                    begin
                        s1_next[k].kind = rpb_pkg::KIND_SAT;
                        s1_next[k].op_b = blue_gain_reg;
                    end
                end
                default:
                begin
                    s1_next[k].kind = rpb_pkg::KIND_DIRECT;
                end
            endcase
        end
    end

    // stage 2: multiply, double for overlay
    always_comb
    begin
        logic [15:0] p;
        for (int k = 0; k < NCH; k++)
        begin
            p = s1_reg[k].op_a * s1_reg[k].op_b;
            s2_next[k].kind   = s1_reg[k].kind;
            s2_next[k].inv    = s1_reg[k].inv;
            s2_next[k].prod   = s1_reg[k].dbl ? {p, 1'b0} : {1'b0, p};
            s2_next[k].direct = s1_reg[k].direct;
        end
    end

    // stage 3: x = n + 127, estimate x/255 as (x + x/256) / 256, low by at most one
    always_comb
    begin
        logic [16:0] x;
        logic [16:0] y;
        for (int k = 0; k < NCH; k++)
        begin
            x = s2_reg[k].prod + 17'd127;
            y = x + {8'd0, x[16:8]};
            s3_next[k].is_div = (s2_reg[k].kind == rpb_pkg::KIND_DIV);
            s3_next[k].inv    = s2_reg[k].inv;
            s3_next[k].num    = x;
            s3_next[k].quot   = y[16:8];
            case (s2_reg[k].kind)
                rpb_pkg::KIND_SAT:
                    s3_next[k].direct = (|s2_reg[k].prod[16:8]) ?
                                        '1 : s2_reg[k].prod[CW-1:0];
                default:
                    s3_next[k].direct = s2_reg[k].direct;
            endcase
        end
    end

    // stage 4: correct the quotient, apply inversion, select
    always_comb
    begin
        logic [16:0] rem;
        logic [8:0]  q;
        for (int k = 0; k < NCH; k++)
        begin
            rem = s3_reg[k].num - ({s3_reg[k].quot, 8'd0} - {8'd0, s3_reg[k].quot});
            q   = (rem >= 17'd255) ? s3_reg[k].quot + 9'd1 : s3_reg[k].quot;
            if (!s3_reg[k].is_div)
                s4_next[k] = s3_reg[k].direct;
            else if (s3_reg[k].inv)
                s4_next[k] = 8'd255 - q[CW-1:0];
            else
                s4_next[k] = q[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) s3_reg <= s3_next;
        if (adv4) s4_reg <= s4_next;
    end

    assign out_valid          = v4_reg;
    assign out_data.out_red   = s4_reg[0];
    assign out_data.out_green = s4_reg[1];
    assign out_data.out_blue  = s4_reg[2];

    `RPB_ASSERT_IMP(a_flow_through, out_ready, in_ready)
    `RPB_ASSERT_IMP(a_blocked_front, v1_reg && !adv2, !in_ready)
    `RPB_ASSERT_NEXT(a_stall_keeps_s3, v3_reg && out_valid && !out_ready, v3_reg)
    `RPB_ASSERT_NEXT(a_s1_drains, v1_reg && adv2 && !in_valid, !v1_reg)

endmodule

>>> bench/pixel_blend_checker.sv
// Checker for the pixel blend unit: watches the input, output and register channels,
// predicts each blended pixel and compares it with what the unit delivers.
// Depends on rpb_pkg.
`timescale 1ns / 100ps

module pixel_blend_checker
    import rpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  pixel_in_t  in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  pixel_out_t out_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    output int         mismatch_count,
    output int         pending
);

    // Shadow copy of the register file
    logic [1:0] add_channel;
    int         add_offset;
    logic [7:0] red_gain;
    logic [7:0] blue_gain;

    pixel_out_t expected_pixels[$];
    int         fails;

    // Round to nearest; no ties since 255 is odd
    function automatic int div255(input int n);
        return (n + 127) / 255;
    endfunction

    function automatic logic [7:0] clamp_byte(input int v);
        if (v < 0)
            return 8'h00;
        if (v > 255)
            return 8'hFF;
        return v[7:0];
    endfunction

    function automatic logic [7:0] blend_channel(input logic [2:0] f, input int t, input int b);
        case (f)
            FUNC_MULTIPLY: return 8'(div255(t * b));
            FUNC_SUBTRACT: return clamp_byte(b - t);
            FUNC_SCREEN:   return 8'(255 - div255((255 - t) * (255 - b)));
            default:
            begin
                if (b <= 127)
                    return 8'(div255(2 * t * b));
                return 8'(255 - div255(2 * (255 - t) * (255 - b)));
            end
        endcase
    endfunction

    function automatic pixel_out_t blend_pixel(input pixel_in_t px);
        logic [7:0] t [NUM_CH];
        logic [7:0] b [NUM_CH];
        logic [7:0] r [NUM_CH];
        pixel_out_t res;
        t[0] = px.top_red;
        t[1] = px.top_green;
        t[2] = px.top_blue;
        b[0] = px.bottom_red;
        b[1] = px.bottom_green;
        b[2] = px.bottom_blue;
        for (int k = 0; k < NUM_CH; k++)
            r[k] = t[k];
        case (px.func)
            FUNC_MULTIPLY, FUNC_SUBTRACT, FUNC_SCREEN, FUNC_OVERLAY:
            begin
                for (int k = 0; k < NUM_CH; k++)
                    r[k] = blend_channel(px.func, int'(t[k]), int'(b[k]));
            end
            FUNC_ADD:
            begin
                // channel code 3 leaves the pixel alone
                if (add_channel < NUM_CH)
                    r[add_channel] = clamp_byte(int'(t[add_channel]) + add_offset);
            end
            FUNC_SCALE:
            begin
                r[0] = clamp_byte(int'(t[0]) * int'(red_gain));
                r[2] = clamp_byte(int'(t[2]) * int'(blue_gain));
            end
            default:
            begin
                // spare codes pass the top pixel through
            end
        endcase
        res.out_red   = r[0];
        res.out_green = r[1];
        res.out_blue  = r[2];
        return res;
    endfunction

    always @(posedge clk)
    begin
        pixel_out_t want;
        if (!rst_n)
        begin
            add_channel = 2'd0;
            add_offset  = 0;
            red_gain    = 8'd1;
            blue_gain   = 8'd1;
            fails       = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ADD_CHANNEL: add_channel = cfg_data[1:0];
                    CFG_ADD_AMOUNT:  add_offset  = int'($signed(cfg_data));
                    CFG_RED_GAIN:    red_gain    = cfg_data[7:0];
                    CFG_BLUE_GAIN:   blue_gain   = cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    fails++;
                    $display("%0t: pixel out with none expected: expected none, got %h",
                        $time, out_data);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (out_data !== want)
                    begin
                        fails++;
                        $display("%0t: mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                            $time, want.out_red, want.out_green, want.out_blue,
                            out_data.out_red, out_data.out_green, out_data.out_blue);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_pixels.insert(expected_pixels.size(), blend_pixel(in_data));
        end
        mismatch_count <= fails;
        pending        <= expected_pixels.size();
    end

endmodule

>>> bench/rgb_pixel_blend_unit_test.sv
// Top of the pixel blend unit bench: clock, reset, pixel and register stimulus, verdict.
// Depends on rpb_pkg, rgb_pixel_blend_unit and pixel_blend_checker.
`timescale 1ns / 100ps

module rgb_pixel_blend_unit_test;
    import rpb_pkg::*;

    localparam logic [2:0] FUNC_SPARE_A = 3'd6;
    localparam logic [2:0] FUNC_SPARE_B = 3'd7;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;

    localparam int RANDOM_PER_PHASE = 190;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    pixel_in_t  in_data;
    logic       out_valid;
    logic       out_ready = 1'b0;
    pixel_out_t out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    int mismatch_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct = 0;

    rgb_pixel_blend_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pixel_blend_checker pb_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Favor the clamp points and the overlay split at 127/128
    function automatic logic [7:0] pick_level();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'(127 + $urandom_range(1));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        if ($urandom_range(19) == 0)
            p.func = $urandom_range(1) ? FUNC_SPARE_A : FUNC_SPARE_B;
        else
            p.func = 3'($urandom_range(FUNC_SCALE));
        p.top_red      = pick_level();
        p.top_green    = pick_level();
        p.top_blue     = pick_level();
        p.bottom_red   = pick_level();
        p.bottom_green = pick_level();
        p.bottom_blue  = pick_level();
        return p;
    endfunction

    task automatic send_pixel(input pixel_in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Leave cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input cfg_idx_t idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_config(input logic [1:0] ch, input logic [8:0] amount,
                                input logic [7:0] rgain, input logic [7:0] bgain);
        // upper data bits are don't-care for the narrow registers; toggle them
        write_reg(CFG_ADD_CHANNEL, {7'($urandom_range(127)), ch});
        write_reg(CFG_ADD_AMOUNT, amount);
        write_reg(CFG_RED_GAIN, {1'($urandom_range(1)), rgain});
        write_reg(CFG_BLUE_GAIN, {1'($urandom_range(1)), bgain});
        cfg_valid <= 1'b0;
    endtask

    // The pending count is registered and trails the last transfer; wait it out first
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 70; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 70; end
            default:       begin send_idle_pct = 10; stall_pct = 10; end
        endcase
    endtask

    task automatic run_phase(input logic [1:0] ch, input logic [8:0] amount,
                             input logic [7:0] rgain, input logic [7:0] bgain,
                             input idle_mode_t mode);
        pixel_in_t p;
        wait_idle();
        apply_config(ch, amount, rgain, bgain);
        set_idle(mode);
        // drive add and scale into both clamp ends under the new setting
        for (int k = 0; k < 4; k++)
        begin
            p = random_pixel();
            p.func      = (k < 2) ? FUNC_ADD : FUNC_SCALE;
            p.top_red   = (k % 2) ? 8'hFF : 8'h00;
            p.top_green = p.top_red;
            p.top_blue  = p.top_red;
            send_pixel(p);
        end
        repeat (RANDOM_PER_PHASE) send_pixel(random_pixel());
    endtask

    initial
    begin
        pixel_in_t p;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ADD_CHANNEL;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults, every func code at the channel extremes and the overlay split
        set_idle(IDLE_NONE);
        for (int f = 0; f < 8; f++)
        begin
            p.func         = 3'(f);
            p.top_red      = 8'h00;
            p.top_green    = 8'hFF;
            p.top_blue     = 8'hFF;
            p.bottom_red   = 8'h00;
            p.bottom_green = 8'hFF;
            p.bottom_blue  = 8'h00;
            send_pixel(p);
            p.top_red      = 8'hFF;
            p.top_green    = 8'h00;
            p.top_blue     = 8'h80;
            p.bottom_red   = 8'hFF;
            p.bottom_green = 8'h7F;
            p.bottom_blue  = 8'h80;
            send_pixel(p);
        end
        repeat (RANDOM_PER_PHASE) send_pixel(random_pixel());

        run_phase(CH_RED, 9'(255), 8'd0, 8'd255, IDLE_NONE);
        run_phase(CH_GREEN, 9'(-255), 8'd255, 8'd0, IDLE_SENDER);
        // the most negative offset, -256, clamps to zero
        run_phase(CH_BLUE, 9'(-256), 8'd2, 8'd3, IDLE_RECEIVER);
        run_phase(CH_NONE, 9'(100), 8'd128, 8'd1, IDLE_BOTH);
        for (int ph = 0; ph < 5; ph++)
            run_phase(2'($urandom_range(3)), 9'($urandom_range(511)), pick_level(),
                      pick_level(), idle_mode_t'(ph % 4));

        in_valid <= 1'b0;
        @(posedge clk);
        for (int n = 0; n < 5000 && pending != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending != 0)
            $display("%0t: %0d pixels never came out", $time, pending);
        if (mismatch_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
